/* rtl/sobel_pkg.sv */
// shared types, constants and kernel weight functions of the sobel edge threshold unit
// no dependencies; imported by every module of the block
package sobel_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int LIMIT_W    = 30;
    localparam int MAX_HEIGHT = 4096;
    localparam int HGT_W      = 13;   // holds MAX_HEIGHT itself
    localparam int ROW_W      = 13;   // row counters, including flush rows past the frame
    localparam int WT_W       = 6;    // signed kernel weight
    localparam int GRAD_W     = 16;   // signed gx / gy, 5x5 peak is 84 * 255
    localparam int SQ_W       = 29;   // gx squared
    localparam int SUM_W      = 30;   // gx squared plus gy squared

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_MODE  = 2'd2,
        REG_MAG_LIMIT_SQ = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             flush;
    } t_in_beat;

    typedef struct packed {
        logic edge_res;
        logic frame_end;
    } t_out_beat;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic emit;    // item produces a result
        logic last;    // result is the last of the frame
        logic half2;   // 5x5 kernels
    } t_tag;

    localparam logic signed [WT_W-1:0] GX3 [9] = '{
        -6'sd1, 6'sd0, 6'sd1,
        -6'sd2, 6'sd0, 6'sd2,
        -6'sd1, 6'sd0, 6'sd1
    };

    localparam logic signed [WT_W-1:0] GX5 [25] = '{
        -6'sd5,  -6'sd4,  6'sd0, 6'sd4,  6'sd5,
        -6'sd8,  -6'sd10, 6'sd0, 6'sd10, 6'sd8,
        -6'sd10, -6'sd20, 6'sd0, 6'sd20, 6'sd10,
        -6'sd8,  -6'sd10, 6'sd0, 6'sd10, 6'sd8,
        -6'sd5,  -6'sd4,  6'sd0, 6'sd4,  6'sd5
    };

    // weight of the horizontal kernel at window slot (k rows back, d items back)
    function automatic logic signed [WT_W-1:0] f_weight_x(input logic half2, input int k,
                                                         input int d);
        logic signed [WT_W-1:0] wt;
        wt = '0;
        if (half2) begin
            wt = GX5[(4 - k) * 5 + (4 - d)];
        end else if (k <= 2 && d <= 2) begin
            wt = GX3[(2 - k) * 3 + (2 - d)];
        end
        return wt;
    endfunction

    // vertical kernel is the transpose
    function automatic logic signed [WT_W-1:0] f_weight_y(input logic half2, input int k,
                                                         input int d);
        return f_weight_x(half2, d, k);
    endfunction

endpackage

/* rtl/sobel_ctrl.sv */
// config registers, frame position counters and the item admission stage
// depends on sobel_pkg; drives the line memory read port of sobel_line_buf
module sobel_ctrl import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  t_in_beat              i_in_data,
    output logic                  o_in_stall,
    output logic [LIMIT_W-1:0]    o_limit,
    output logic                  o_rd_en,
    output logic [COL_W-1:0]      o_rd_addr,
    output logic                  o_v,
    input  logic                  i_rdy,
    output logic [PIX_W-1:0]      o_gray,
    output logic [COL_W-1:0]      o_col,
    output logic [ROW_W-1:0]      o_orow,
    output logic [COL_W-1:0]      o_ocol,
    output logic [WID_W-1:0]      o_w,
    output logic [HGT_W-1:0]      o_h,
    output t_tag                  o_tag
);

    localparam int LAG_W = $clog2(2 * MAX_WIDTH + 3);

    logic [CFG_WID_W-1:0] r_frame_width;
    logic [CFG_HGT_W-1:0] r_frame_height;
    logic                 r_kernel_mode;
    logic [LIMIT_W-1:0]   r_limit;

    logic               r_active, n_active;
    logic [WID_W-1:0]   r_lat_w, n_lat_w;
    logic [HGT_W-1:0]   r_lat_h, n_lat_h;
    logic               r_lat_half2, n_lat_half2;
    logic [ROW_W-1:0]   r_in_row, n_in_row;
    logic [COL_W-1:0]   r_in_col, n_in_col;
    logic [ROW_W-1:0]   r_out_row, n_out_row;
    logic [COL_W-1:0]   r_out_col, n_out_col;
    logic [LAG_W-1:0]   r_lag_cnt, n_lag_cnt;

    logic               r_a_v;
    logic [PIX_W-1:0]   r_a_gray;
    logic [COL_W-1:0]   r_a_col;
    logic [ROW_W-1:0]   r_a_orow;
    logic [COL_W-1:0]   r_a_ocol;
    logic [WID_W-1:0]   r_a_w;
    logic [HGT_W-1:0]   r_a_h;
    t_tag               r_a_tag;

    logic             start, pixel_phase, accept, take, emit, last, col_wrap, ocol_wrap;
    logic [WID_W-1:0] w_cfg, w_cur;
    logic [HGT_W-1:0] h_cfg, h_cur;
    logic             half2_cfg, half2_cur;
    logic [LAG_W-1:0] lag_cfg;
    logic             a_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_WID_W'(640);
            r_frame_height <= CFG_HGT_W'(480);
            r_kernel_mode  <= 1'b0;
            r_limit        <= LIMIT_W'(10000);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[CFG_WID_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[CFG_HGT_W-1:0];
                REG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_wdata[0];
                REG_MAG_LIMIT_SQ: r_limit        <= i_cfg_wdata[LIMIT_W-1:0];
            endcase
        end
    end

    assign o_limit = r_limit;

    // clamped frame geometry, taken at the first pixel of a frame
    always_comb begin
        if (r_frame_width == '0) begin
            w_cfg = WID_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_cfg = WID_W'(MAX_WIDTH);
        end else begin
            w_cfg = WID_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_cfg = HGT_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_cfg = HGT_W'(MAX_HEIGHT);
        end else begin
            h_cfg = HGT_W'(r_frame_height);
        end
    end

    assign half2_cfg = r_kernel_mode && (MAX_KERNEL >= 5);
    assign lag_cfg   = half2_cfg ? (LAG_W'(w_cfg) << 1) + LAG_W'(2) : LAG_W'(w_cfg) + LAG_W'(1);

    assign start       = !r_active;
    assign w_cur       = start ? w_cfg : r_lat_w;
    assign h_cur       = start ? h_cfg : r_lat_h;
    assign half2_cur   = start ? half2_cfg : r_lat_half2;
    assign pixel_phase = start || (r_in_row < ROW_W'(r_lat_h));

    assign a_adv      = r_a_v && i_rdy;
    assign o_in_stall = r_a_v && !i_rdy;
    assign accept     = i_in_valid && !o_in_stall;
    // a flush while pixels are still due is dropped
    assign take       = accept && !(i_in_data.flush && pixel_phase);

    assign emit      = !start && (r_lag_cnt == '0);
    assign last      = emit && (r_out_row == ROW_W'(h_cur - HGT_W'(1)))
                            && (r_out_col == COL_W'(w_cur - WID_W'(1)));
    assign col_wrap  = (WID_W'(r_in_col) + WID_W'(1)) == w_cur;
    assign ocol_wrap = (WID_W'(r_out_col) + WID_W'(1)) == w_cur;

    always_comb begin
        n_active    = r_active;
        n_lat_w     = r_lat_w;
        n_lat_h     = r_lat_h;
        n_lat_half2 = r_lat_half2;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_lag_cnt   = r_lag_cnt;
        if (take) begin
            n_active    = 1'b1;
            n_lat_w     = w_cur;
            n_lat_h     = h_cur;
            n_lat_half2 = half2_cur;
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (start) begin
                n_lag_cnt = lag_cfg - LAG_W'(1);
            end else if (!emit) begin
                n_lag_cnt = r_lag_cnt - LAG_W'(1);
            end
            if (emit) begin
                if (ocol_wrap) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
            if (last) begin
                n_active  = 1'b0;
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
                n_lag_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_lat_w     <= WID_W'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
            r_lat_h     <= HGT_W'(480);
            r_lat_half2 <= 1'b0;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_lag_cnt   <= '0;
            r_a_v       <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_lat_w     <= n_lat_w;
            r_lat_h     <= n_lat_h;
            r_lat_half2 <= n_lat_half2;
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_lag_cnt   <= n_lag_cnt;
            if (take) begin
                r_a_v <= 1'b1;
            end else if (a_adv) begin
                r_a_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_gray <= pixel_phase ? i_in_data.gray : '0;
            r_a_col  <= r_in_col;
            r_a_orow <= r_out_row;
            r_a_ocol <= r_out_col;
            r_a_w    <= w_cur;
            r_a_h    <= h_cur;
            r_a_tag  <= '{emit: emit, last: last, half2: half2_cur};
        end
    end

    assign o_rd_en   = take;
    assign o_rd_addr = r_in_col;
    assign o_v       = r_a_v;
    assign o_gray    = r_a_gray;
    assign o_col     = r_a_col;
    assign o_orow    = r_a_orow;
    assign o_ocol    = r_a_ocol;
    assign o_w       = r_a_w;
    assign o_h       = r_a_h;
    assign o_tag     = r_a_tag;

endmodule

/* rtl/sobel_line_buf.sv */
// column-stacked line memory with read-modify-write, the pixel window and edge masks
// depends on sobel_pkg; read address comes from sobel_ctrl in the cycle before its item
module sobel_line_buf import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int WID_W = $clog2(MAX_WIDTH + 1),
    localparam int KW    = MAX_KERNEL
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [COL_W-1:0]   i_rd_addr,
    input  logic               i_v,
    output logic               o_rdy,
    input  logic [PIX_W-1:0]   i_gray,
    input  logic [COL_W-1:0]   i_col,
    input  logic [ROW_W-1:0]   i_orow,
    input  logic [COL_W-1:0]   i_ocol,
    input  logic [WID_W-1:0]   i_w,
    input  logic [HGT_W-1:0]   i_h,
    input  t_tag               i_tag,
    output logic               o_v,
    input  logic               i_rdy,
    output logic [PIX_W-1:0]   o_win [KW][KW],
    output logic [KW-1:0]      o_row_ok,
    output logic [KW-1:0]      o_col_ok,
    output t_tag               o_tag
);

    localparam int MW   = (KW - 1) * PIX_W;
    localparam int RR_W = ROW_W + 2;
    localparam int CC_W = WID_W + 2;

    logic [MW-1:0]    r_line_mem [MAX_WIDTH];
    logic [MW-1:0]    r_rd_data;
    logic             r_fwd_hit;
    logic [MW-1:0]    r_fwd_data;
    logic             r_b_v;
    logic [PIX_W-1:0] r_win [KW][KW];
    logic [KW-1:0]    r_row_ok, r_col_ok;
    t_tag             r_b_tag;

    logic [MW-1:0]    rd_vec, wr_data;
    logic [PIX_W-1:0] col_v [KW];
    logic             wr_en, b_adv;
    logic [KW-1:0]    row_ok, col_ok;
    logic signed [RR_W-1:0] rr;
    logic signed [CC_W-1:0] cc;
    logic [1:0]       half;

    assign b_adv = r_b_v && i_rdy;
    assign o_rdy = !r_b_v || b_adv;
    assign wr_en = i_v && o_rdy;

    // a write to the address being read in the same cycle is forwarded
    assign rd_vec  = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign wr_data = {rd_vec[MW-PIX_W-1:0], i_gray};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[i_col] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_line_mem[i_rd_addr];
            r_fwd_hit  <= wr_en && (i_col == i_rd_addr);
            r_fwd_data <= wr_data;
        end
    end

    always_comb begin
        col_v[0] = i_gray;
        for (int k = 1; k < KW; k++) begin
            col_v[k] = rd_vec[(k-1)*PIX_W +: PIX_W];
        end
    end

    // slot (k, d) holds frame pixel (orow + h - k, ocol + h - d)
    always_comb begin
        half = i_tag.half2 ? 2'd2 : 2'd1;
        rr   = '0;
        cc   = '0;
        for (int k = 0; k < KW; k++) begin
            rr = $signed(RR_W'(i_orow)) + $signed(RR_W'(half)) - $signed(RR_W'(k));
            row_ok[k] = (rr >= 0) && (rr < $signed(RR_W'(i_h)));
        end
        for (int d = 0; d < KW; d++) begin
            cc = $signed(CC_W'(i_ocol)) + $signed(CC_W'(half)) - $signed(CC_W'(d));
            col_ok[d] = (cc >= 0) && (cc < $signed(CC_W'(i_w)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (wr_en) begin
            r_b_v <= 1'b1;
        end else if (b_adv) begin
            r_b_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int k = 0; k < KW; k++) begin
                r_win[k][0] <= col_v[k];
                for (int d = 1; d < KW; d++) begin
                    r_win[k][d] <= r_win[k][d-1];
                end
            end
            r_row_ok <= row_ok;
            r_col_ok <= col_ok;
            r_b_tag  <= i_tag;
        end
    end

    assign o_v      = r_b_v;
    assign o_win    = r_win;
    assign o_row_ok = r_row_ok;
    assign o_col_ok = r_col_ok;
    assign o_tag    = r_b_tag;

endmodule

/* rtl/sobel_grad.sv */
// horizontal and vertical gradient sums: per-row partials, then the row total
// depends on sobel_pkg kernel weights; fed by sobel_line_buf
module sobel_grad import sobel_pkg::*; #(
    parameter int MAX_KERNEL = 5,
    localparam int KW = MAX_KERNEL
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_v,
    output logic                     o_rdy,
    input  logic [PIX_W-1:0]         i_win [KW][KW],
    input  logic [KW-1:0]            i_row_ok,
    input  logic [KW-1:0]            i_col_ok,
    input  t_tag                     i_tag,
    output logic                     o_v,
    input  logic                     i_rdy,
    output logic signed [GRAD_W-1:0] o_gx,
    output logic signed [GRAD_W-1:0] o_gy,
    output t_tag                     o_tag
);

    logic                     r_c_v, r_d_v;
    logic signed [GRAD_W-1:0] r_c_gx [KW];
    logic signed [GRAD_W-1:0] r_c_gy [KW];
    t_tag                     r_c_tag, r_d_tag;
    logic signed [GRAD_W-1:0] r_d_gx, r_d_gy;

    logic signed [GRAD_W-1:0] gx_row [KW];
    logic signed [GRAD_W-1:0] gy_row [KW];
    logic signed [GRAD_W-1:0] gx_sum, gy_sum;
    logic                     c_load, c_adv, d_load, d_adv;

    assign d_adv  = r_d_v && i_rdy;
    assign d_load = r_c_v && (!r_d_v || d_adv);
    assign c_adv  = d_load;
    assign c_load = i_v && (!r_c_v || c_adv);
    assign o_rdy  = !r_c_v || c_adv;

    always_comb begin
        logic [PIX_W-1:0] px;
        px = '0;
        for (int k = 0; k < KW; k++) begin
            gx_row[k] = '0;
            gy_row[k] = '0;
            for (int d = 0; d < KW; d++) begin
                px = (i_row_ok[k] && i_col_ok[d]) ? i_win[k][d] : '0;
                gx_row[k] = gx_row[k] + $signed(GRAD_W'(px))
                            * GRAD_W'(f_weight_x(i_tag.half2, k, d));
                gy_row[k] = gy_row[k] + $signed(GRAD_W'(px))
                            * GRAD_W'(f_weight_y(i_tag.half2, k, d));
            end
        end
    end

    always_comb begin
        gx_sum = '0;
        gy_sum = '0;
        for (int k = 0; k < KW; k++) begin
            gx_sum = gx_sum + r_c_gx[k];
            gy_sum = gy_sum + r_c_gy[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (c_load) begin
                r_c_v <= 1'b1;
            end else if (c_adv) begin
                r_c_v <= 1'b0;
            end
            if (d_load) begin
                r_d_v <= 1'b1;
            end else if (d_adv) begin
                r_d_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_c_gx  <= gx_row;
            r_c_gy  <= gy_row;
            r_c_tag <= i_tag;
        end
        if (d_load) begin
            r_d_gx  <= gx_sum;
            r_d_gy  <= gy_sum;
            r_d_tag <= r_c_tag;
        end
    end

    assign o_v   = r_d_v;
    assign o_gx  = r_d_gx;
    assign o_gy  = r_d_gy;
    assign o_tag = r_d_tag;

endmodule

/* rtl/sobel_mag.sv */
// squared magnitude, threshold compare and the result output register
// depends on sobel_pkg; fed by sobel_grad, limit from sobel_ctrl
module sobel_mag import sobel_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [LIMIT_W-1:0]       i_limit,
    input  logic                     i_v,
    output logic                     o_rdy,
    input  logic signed [GRAD_W-1:0] i_gx,
    input  logic signed [GRAD_W-1:0] i_gy,
    input  t_tag                     i_tag,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_beat                o_out_data
);

    logic             r_e_v;
    t_tag             r_e_tag;
    logic [SQ_W-1:0]  r_e_gx2, r_e_gy2;
    logic             r_out_v;
    t_out_beat        r_out_data;

    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SUM_W-1:0]           mag_sq;
    logic                       out_free, e_adv, e_load, out_load;

    assign gx_sq = i_gx * i_gx;
    assign gy_sq = i_gy * i_gy;

    assign out_free = !r_out_v || !i_out_stall;
    // items that produce no result leave here without a beat
    assign e_adv    = r_e_v && (!r_e_tag.emit || out_free);
    assign e_load   = i_v && (!r_e_v || e_adv);
    assign o_rdy    = !r_e_v || e_adv;
    assign out_load = e_adv && r_e_tag.emit;

    assign mag_sq = SUM_W'(r_e_gx2) + SUM_W'(r_e_gy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (e_load) begin
                r_e_v <= 1'b1;
            end else if (e_adv) begin
                r_e_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_e_gx2 <= gx_sq[SQ_W-1:0];
            r_e_gy2 <= gy_sq[SQ_W-1:0];
            r_e_tag <= i_tag;
        end
        if (out_load) begin
            r_out_data <= '{edge_res: (mag_sq > i_limit), frame_end: r_e_tag.last};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/sobel_edge_threshold_unit.sv */
// sobel edge threshold unit: streaming 3x3 / 5x5 sobel gradient with a squared-magnitude
// threshold. Gray pixels enter in raster order, one per clock, and each input beat is
// accepted in the cycle it is offered unless the result side is backed up through the
// whole pipeline. The result for pixel (r, c) leaves with the input beat that carries
// item r*W + c + h*W + h of the frame (h = 1 for 3x3, h = 2 for 5x5), so after the
// W*H pixels of a frame the host sends h*W + h flush beats; a flush beat before all
// pixels of a frame are in, or before a frame starts, is taken and dropped. Width,
// height and kernel size are captured with the first pixel of each frame; the limit
// is used live. Throughput is one item per clock, set by the single line memory of
// MAX_WIDTH entries of (MAX_KERNEL-1) pixels that each item reads once and writes
// once; a result passes the admission, window, row-partial, gradient-sum, square and
// output registers in turn. The line memory needs no clearing pass after reset:
// neighbors outside the frame are masked to zero, so stale contents are never used.
// depends on sobel_pkg and the four sobel_* submodules
module sobel_edge_threshold_unit import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel beats
    input  logic                  i_in_valid,
    input  t_in_beat              i_in_data,
    output logic                  o_in_stall,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int KW    = MAX_KERNEL;

    // admission stage -> line buffer
    logic               rd_en;
    logic [COL_W-1:0]   rd_addr;
    logic               a_v, a_rdy;
    logic [PIX_W-1:0]   a_gray;
    logic [COL_W-1:0]   a_col, a_ocol;
    logic [ROW_W-1:0]   a_orow;
    logic [WID_W-1:0]   a_w;
    logic [HGT_W-1:0]   a_h;
    t_tag               a_tag;
    logic [LIMIT_W-1:0] limit;

    // line buffer -> gradient
    logic               b_v, b_rdy;
    logic [PIX_W-1:0]   b_win [KW][KW];
    logic [KW-1:0]      b_row_ok, b_col_ok;
    t_tag               b_tag;

    // gradient -> magnitude
    logic                     g_v, g_rdy;
    logic signed [GRAD_W-1:0] g_gx, g_gy;
    t_tag                     g_tag;

    // counters, config and the pixel / flush decision
    sobel_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_limit     (limit),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_v         (a_v),
        .i_rdy       (a_rdy),
        .o_gray      (a_gray),
        .o_col       (a_col),
        .o_orow      (a_orow),
        .o_ocol      (a_ocol),
        .o_w         (a_w),
        .o_h         (a_h),
        .o_tag       (a_tag)
    );

    // line memory read-modify-write and the sliding window
    sobel_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_v       (a_v),
        .o_rdy     (a_rdy),
        .i_gray    (a_gray),
        .i_col     (a_col),
        .i_orow    (a_orow),
        .i_ocol    (a_ocol),
        .i_w       (a_w),
        .i_h       (a_h),
        .i_tag     (a_tag),
        .o_v       (b_v),
        .i_rdy     (b_rdy),
        .o_win     (b_win),
        .o_row_ok  (b_row_ok),
        .o_col_ok  (b_col_ok),
        .o_tag     (b_tag)
    );

    // gx / gy over two stages
    sobel_grad #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_v      (b_v),
        .o_rdy    (b_rdy),
        .i_win    (b_win),
        .i_row_ok (b_row_ok),
        .i_col_ok (b_col_ok),
        .i_tag    (b_tag),
        .o_v      (g_v),
        .i_rdy    (g_rdy),
        .o_gx     (g_gx),
        .o_gy     (g_gy),
        .o_tag    (g_tag)
    );

    // squares, threshold and the output register
    sobel_mag u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (limit),
        .i_v         (g_v),
        .o_rdy       (g_rdy),
        .i_gx        (g_gx),
        .i_gy        (g_gy),
        .i_tag       (g_tag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/sobel_chk.sv */
// port-level checker for the sobel edge threshold unit, with its bind statement
// depends on sobel_pkg; attaches to sobel_edge_threshold_unit
module sobel_chk import sobel_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                  i_in_valid,
    input t_in_beat              i_in_data,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_beat             o_out_data
);

    // a reset cycle leaves no result beat pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present right after reset");

    // input back-pressure only arises from a blocked full output register
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the result side is free");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed or vanished");

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input beat changed or vanished");

    // register writes only with the result side idle, index and value known
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |-> (!o_out_valid && !$isunknown({i_cfg_idx, i_cfg_wdata})))
        else $error("register write with a result pending or unknown data");

endmodule

bind sobel_edge_threshold_unit sobel_chk u_sobel_chk (.*);
